// File: design/arf_pkg.sv
// Shared types and constants for the adaptive refresh interval block.
package arf_pkg;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int IVL_W       = 20;
    localparam int PCT_W       = 7;
    localparam int TICK_W      = 64;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX      = 3'd5;

    // reset values
    localparam logic             RST_ENABLE = 1'b0;
    localparam logic [IVL_W-1:0] RST_BASE   = 20'd1000;
    localparam logic [PCT_W-1:0] RST_HIGH   = 7'd22;
    localparam logic [PCT_W-1:0] RST_LOW    = 7'd18;
    localparam logic [IVL_W-1:0] RST_MIN    = 20'd1000;
    localparam logic [IVL_W-1:0] RST_MAX    = 20'd100000;

    localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;

    // interval scale factors, all over ten
    localparam logic [3:0] SCALE_GROW   = 4'd11;
    localparam logic [3:0] SCALE_SHRINK = 4'd9;
    localparam logic [3:0] SCALE_KEEP   = 4'd10;

    // floor(x/10) = (x * RECIP_TEN) >> RECIP_SHIFT, exact for x < 2^26
    localparam int             SCALED_W    = 24;
    localparam int             RECIP_SHIFT = 27;
    localparam logic [23:0]    RECIP_TEN   = 24'hCCCCCD;

    typedef struct packed {
        logic              restart;
        logic [TICK_W-1:0] total_ticks;
        logic [TICK_W-1:0] own_ticks;
    } arf_in_t;

    typedef struct packed {
        logic             changed;
        logic [IVL_W-1:0] interval_out;
        logic [PCT_W-1:0] usage_percent;
    } arf_out_t;

    typedef struct packed {
        logic             enable;
        logic [IVL_W-1:0] base_interval;
        logic [PCT_W-1:0] usage_high;
        logic [PCT_W-1:0] usage_low;
        logic [IVL_W-1:0] min_interval;
        logic [IVL_W-1:0] max_interval;
    } arf_cfg_t;

    typedef struct packed {
        logic       load;
        logic       prep;
        logic       mul1;
        logic       mul2;
        logic       div_step;
        logic [2:0] div_shift;
        logic       scale;
        logic       recip;
        logic       clamp;
        logic       commit;
    } arf_cmd_t;

    typedef struct packed {
        logic skip;
    } arf_status_t;

endpackage

// File: design/adaptive_refresh_interval.sv
// Top level: configuration registers, sequencer and datapath of the interval controller.
// Sequence: a normal enabled update passes through prep, the mul1 and mul2 steps, the
// seven restoring steps of the usage divider, scale, reciprocal multiply, clamp and commit;
// a restart or a disabled update goes from prep straight to commit. The commit waits while
// the output slot is held, and no new transaction is accepted until it is done.
// Reset: configuration returns to defaults, interval 1000, last usage 18, baselines zero.
module adaptive_refresh_interval (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [arf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [arf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  arf_pkg::arf_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output arf_pkg::arf_out_t                   out_data
);

    arf_pkg::arf_cfg_t    cfg_reg, cfg_next;
    arf_pkg::arf_cmd_t    cmd;
    arf_pkg::arf_status_t status;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                arf_pkg::CFG_ENABLE: cfg_next.enable        = cfg_wdata[0];
                arf_pkg::CFG_BASE:   cfg_next.base_interval = cfg_wdata[arf_pkg::IVL_W-1:0];
                arf_pkg::CFG_HIGH:   cfg_next.usage_high    = cfg_wdata[arf_pkg::PCT_W-1:0];
                arf_pkg::CFG_LOW:    cfg_next.usage_low     = cfg_wdata[arf_pkg::PCT_W-1:0];
                arf_pkg::CFG_MIN:    cfg_next.min_interval  = cfg_wdata[arf_pkg::IVL_W-1:0];
                arf_pkg::CFG_MAX:    cfg_next.max_interval  = cfg_wdata[arf_pkg::IVL_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable        <= arf_pkg::RST_ENABLE;
            cfg_reg.base_interval <= arf_pkg::RST_BASE;
            cfg_reg.usage_high    <= arf_pkg::RST_HIGH;
            cfg_reg.usage_low     <= arf_pkg::RST_LOW;
            cfg_reg.min_interval  <= arf_pkg::RST_MIN;
            cfg_reg.max_interval  <= arf_pkg::RST_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    arf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    arf_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

// File: design/arf_ctrl.sv
// Sequencer for the adaptive refresh interval block: handshakes and step control.
module arf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  arf_pkg::arf_status_t status,
    output arf_pkg::arf_cmd_t    cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PREP  = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_MUL2  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_SCALE = 4'd5;
    localparam logic [3:0] S_RECIP = 4'd6;
    localparam logic [3:0] S_CLAMP = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    localparam logic [2:0] DIV_TOP = 3'd6;

    logic [3:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = status.skip ? S_FIN : S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                step_next  = DIV_TOP;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_shift = step_reg;
                if (step_reg == 3'd0)
                    state_next = S_SCALE;
                else
                    step_next = step_reg - 3'd1;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_RECIP;
            end
            S_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // wait for the output slot before touching state
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_PREP)
        else $error("accepted transaction did not start processing");

    a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || !out_stall))
        else $error("commit while output slot occupied");

    a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result presented without a commit");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV && step_reg == 3'd0 |=> state_reg == S_SCALE)
        else $error("divider did not finish after its last step");
`endif

endmodule

// File: design/arf_dpath.sv
// Datapath: usage divider, interval scaling and clamping, tracked state.
module arf_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  arf_pkg::arf_cfg_t    cfg,
    input  arf_pkg::arf_in_t     in_data,
    input  arf_pkg::arf_cmd_t    cmd,
    output arf_pkg::arf_status_t status,
    output arf_pkg::arf_out_t    out_data
);

    localparam int TW  = arf_pkg::TICK_W;
    localparam int IW  = arf_pkg::IVL_W;
    localparam int PW  = arf_pkg::PCT_W;
    localparam int SW  = arf_pkg::SCALED_W;
    localparam int RW  = TW + PW;          // busy * 100 fits here
    localparam int PRW = 2 * SW;

    // transaction held during processing
    logic          restart_reg;
    logic [TW-1:0] total_reg;
    logic [TW-1:0] own_reg;

    logic [TW-1:0]  elapsed_reg;
    logic [TW-1:0]  busy_reg;
    logic [RW-1:0]  rem_reg;
    logic           zero_reg;
    logic           sat_reg;
    logic [PW-1:0]  quot_reg;
    logic [PW-1:0]  usage_reg;
    logic [SW-1:0]  scaled_reg;
    logic [PRW-1:0] prod_reg;
    logic [IW:0]    cand_reg;

    logic [IW-1:0] cur_interval_reg, cur_interval_next;
    logic [PW-1:0] prev_usage_reg, prev_usage_next;
    logic [TW-1:0] prev_total_reg, prev_total_next;
    logic [TW-1:0] prev_own_reg, prev_own_next;

    arf_pkg::arf_out_t out_reg;

    logic [RW:0]   trial;
    logic [PW-1:0] usage_calc;
    logic          grow;
    logic          shrink;
    logic [3:0]    factor;
    logic [IW:0]   quot10;
    logic [IW:0]   base_hi;
    logic [IW:0]   base_lo;
    logic [IW:0]   clamp1;
    logic [IW-1:0] clamp2;

    assign status.skip = restart_reg || !cfg.enable;

    assign trial = {1'b0, rem_reg} - ({{(RW + 1 - TW){1'b0}}, elapsed_reg} << cmd.div_shift);

    assign usage_calc = zero_reg ? cfg.usage_low :
                        sat_reg  ? arf_pkg::PCT_FULL : quot_reg;

    assign grow   = (usage_calc > cfg.usage_high) && (prev_usage_reg > cfg.usage_high);
    assign shrink = (cur_interval_reg != cfg.base_interval) &&
                    (usage_calc < cfg.usage_low) && (prev_usage_reg < cfg.usage_low);
    assign factor = grow ? arf_pkg::SCALE_GROW :
                    shrink ? arf_pkg::SCALE_SHRINK : arf_pkg::SCALE_KEEP;

    assign quot10  = prod_reg[arf_pkg::RECIP_SHIFT +: (IW + 1)];
    assign base_hi = {cfg.base_interval, 1'b0};
    assign base_lo = {1'b0, cfg.base_interval};
    assign clamp1  = (quot10 > base_hi) ? base_hi :
                     (quot10 < base_lo) ? base_lo : quot10;

    // max is checked first: when the bounds cross, a candidate above max gets max, any other min
    assign clamp2 = (cand_reg > {1'b0, cfg.max_interval}) ? cfg.max_interval :
                    (cand_reg < {1'b0, cfg.min_interval}) ? cfg.min_interval :
                    cand_reg[IW-1:0];

    always_comb
    begin
        cur_interval_next = cur_interval_reg;
        prev_usage_next   = prev_usage_reg;
        prev_total_next   = prev_total_reg;
        prev_own_next     = prev_own_reg;
        if (restart_reg)
        begin
            prev_total_next   = total_reg;
            prev_own_next     = own_reg;
            cur_interval_next = cfg.base_interval;
            prev_usage_next   = cfg.usage_low;
        end
        else if (cfg.enable)
        begin
            prev_total_next = total_reg;
            if (!zero_reg)
                prev_own_next = own_reg;
            cur_interval_next = clamp2;
            prev_usage_next   = usage_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            restart_reg <= in_data.restart;
            total_reg   <= in_data.total_ticks;
            own_reg     <= in_data.own_ticks;
        end
        if (cmd.prep)
        begin
            elapsed_reg <= total_reg - prev_total_reg;
            busy_reg    <= own_reg - prev_own_reg;
        end
        if (cmd.mul1)
        begin
            rem_reg  <= {1'b0, busy_reg, 6'b0} + {2'b0, busy_reg, 5'b0};
            zero_reg <= (elapsed_reg == '0);
            sat_reg  <= (busy_reg >= elapsed_reg);
        end
        if (cmd.mul2)
            rem_reg <= rem_reg + {5'b0, busy_reg, 2'b0};
        if (cmd.div_step)
        begin
            if (!trial[RW])
                rem_reg <= trial[RW-1:0];
            quot_reg <= {quot_reg[PW-2:0], !trial[RW]};
        end
        if (cmd.scale)
        begin
            usage_reg  <= usage_calc;
            scaled_reg <= {{(SW - IW){1'b0}}, cur_interval_reg} * {{(SW - 4){1'b0}}, factor};
        end
        if (cmd.recip)
            prod_reg <= {{SW{1'b0}}, scaled_reg} * {{SW{1'b0}}, arf_pkg::RECIP_TEN};
        if (cmd.clamp)
            cand_reg <= clamp1;
        if (cmd.commit)
        begin
            out_reg.changed       <= (cur_interval_next != cur_interval_reg);
            out_reg.interval_out  <= cur_interval_next;
            out_reg.usage_percent <= prev_usage_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_interval_reg <= arf_pkg::RST_BASE;
            prev_usage_reg   <= arf_pkg::RST_LOW;
            prev_total_reg   <= '0;
            prev_own_reg     <= '0;
        end
        else if (cmd.commit)
        begin
            cur_interval_reg <= cur_interval_next;
            prev_usage_reg   <= prev_usage_next;
            prev_total_reg   <= prev_total_next;
            prev_own_reg     <= prev_own_next;
        end
    end

    assign out_data = out_reg;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the adaptive refresh interval controller.
module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cfg_we;
    logic [arf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [arf_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic     in_valid;
    logic     in_stall;
    arf_pkg::arf_in_t  in_data;
    logic     out_valid;
    logic     out_stall;
    arf_pkg::arf_out_t out_data;

    adaptive_refresh_interval uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // predictor copy of the registers
    logic                      cfg_enable = arf_pkg::RST_ENABLE;
    logic [arf_pkg::IVL_W-1:0] cfg_base   = arf_pkg::RST_BASE;
    logic [arf_pkg::PCT_W-1:0] cfg_high   = arf_pkg::RST_HIGH;
    logic [arf_pkg::PCT_W-1:0] cfg_low    = arf_pkg::RST_LOW;
    logic [arf_pkg::IVL_W-1:0] cfg_min    = arf_pkg::RST_MIN;
    logic [arf_pkg::IVL_W-1:0] cfg_max    = arf_pkg::RST_MAX;

    // predictor copy of the block state
    logic [arf_pkg::IVL_W-1:0]  cur_interval = arf_pkg::RST_BASE;
    logic [arf_pkg::PCT_W-1:0]  last_usage   = arf_pkg::RST_LOW;
    logic [arf_pkg::TICK_W-1:0] base_total   = '0;
    logic [arf_pkg::TICK_W-1:0] base_busy    = '0;

    arf_pkg::arf_out_t expected_intervals[$];

    int unsigned error_count;
    int unsigned samples_sent;
    int unsigned results_checked;
    int unsigned grow_count;
    int unsigned shrink_count;
    int unsigned restart_count;
    int unsigned cycle_count;
    bit          no_idle;

    // stream position for well-formed counter sequences
    logic [arf_pkg::TICK_W-1:0] total_now;
    logic [arf_pkg::TICK_W-1:0] busy_now;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_intervals.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // floor(busy * 100 / span) saturated to 100, span nonzero
    function automatic logic [arf_pkg::PCT_W-1:0] usage_pct(
        logic [arf_pkg::TICK_W-1:0] busy,
        logic [arf_pkg::TICK_W-1:0] span);
        logic [71:0] scaled;
        logic [71:0] quot;
        if (busy >= span)
            return arf_pkg::PCT_FULL;
        scaled = {8'd0, busy} * arf_pkg::PCT_FULL;
        quot = scaled / {8'd0, span};
        return quot[arf_pkg::PCT_W-1:0];
    endfunction

    function automatic arf_pkg::arf_out_t predict_interval(arf_pkg::arf_in_t s);
        arf_pkg::arf_out_t          r;
        logic [arf_pkg::IVL_W-1:0]  before_ivl;
        logic [arf_pkg::TICK_W-1:0] span;
        logic [arf_pkg::PCT_W-1:0]  pct;
        logic [31:0]                nxt;
        logic [31:0]                upper;
        before_ivl = cur_interval;
        if (s.restart)
        begin
            base_total   = s.total_ticks;
            base_busy    = s.own_ticks;
            cur_interval = cfg_base;
            last_usage   = cfg_low;
            restart_count++;
        end
        else if (cfg_enable)
        begin
            span = s.total_ticks - base_total;
            if (span != '0)
            begin
                pct = usage_pct(s.own_ticks - base_busy, span);
                base_busy = s.own_ticks;
            end
            else
                pct = cfg_low;
            base_total = s.total_ticks;

            nxt = {12'd0, cur_interval};
            if (pct > cfg_high && last_usage > cfg_high)
            begin
                nxt = nxt * arf_pkg::SCALE_GROW / arf_pkg::SCALE_KEEP;
                grow_count++;
            end
            else if (cur_interval != cfg_base && pct < cfg_low && last_usage < cfg_low)
            begin
                nxt = nxt * arf_pkg::SCALE_SHRINK / arf_pkg::SCALE_KEEP;
                shrink_count++;
            end

            // base clamp first, then the absolute bounds
            upper = {12'd0, cfg_base} << 1;
            if (nxt > upper)
                nxt = upper;
            else if (nxt < {12'd0, cfg_base})
                nxt = {12'd0, cfg_base};
            if (nxt > {12'd0, cfg_max})
                nxt = {12'd0, cfg_max};
            else if (nxt < {12'd0, cfg_min})
                nxt = {12'd0, cfg_min};
            cur_interval = nxt[arf_pkg::IVL_W-1:0];
            last_usage   = pct;
        end
        r.changed       = (cur_interval != before_ivl);
        r.interval_out  = cur_interval;
        r.usage_percent = last_usage;
        return r;
    endfunction

    task automatic report_mismatch(string field, int unsigned got, int unsigned want);
        $display("MISMATCH result %0d %s: got %0d expected %0d", results_checked, field,
                 got, want);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        arf_pkg::arf_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_intervals.size() == 0)
                report_mismatch("unexpected transaction", out_data.interval_out, 0);
            else
            begin
                want = expected_intervals.pop_front();
                if (out_data.changed !== want.changed)
                    report_mismatch("changed", out_data.changed, want.changed);
                if (out_data.interval_out !== want.interval_out)
                    report_mismatch("interval_out", out_data.interval_out, want.interval_out);
                if (out_data.usage_percent !== want.usage_percent)
                    report_mismatch("usage_percent", out_data.usage_percent,
                                    want.usage_percent);
            end
            results_checked <= results_checked + 1;
        end
    end

    // receiver backpressure in short random bursts
    int unsigned stall_left;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (rst_n && !no_idle && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send_sample(logic rst, logic [arf_pkg::TICK_W-1:0] total,
                               logic [arf_pkg::TICK_W-1:0] own);
        arf_pkg::arf_in_t s;
        arf_pkg::arf_in_t junk;
        int unsigned      gap;
        s.restart         = rst;
        s.total_ticks     = total;
        s.own_ticks       = own;
        junk.restart      = 1'($urandom_range(0, 1));
        junk.total_ticks  = {$urandom, $urandom};
        junk.own_ticks    = {$urandom, $urandom};
        gap = (!no_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            in_data  <= junk;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_intervals.push_back(predict_interval(s));
        samples_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_intervals.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [arf_pkg::CFG_IDX_W-1:0] idx,
                             logic [arf_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            arf_pkg::CFG_ENABLE: cfg_enable = val[0];
            arf_pkg::CFG_BASE:   cfg_base   = val[arf_pkg::IVL_W-1:0];
            arf_pkg::CFG_HIGH:   cfg_high   = val[arf_pkg::PCT_W-1:0];
            arf_pkg::CFG_LOW:    cfg_low    = val[arf_pkg::PCT_W-1:0];
            arf_pkg::CFG_MIN:    cfg_min    = val[arf_pkg::IVL_W-1:0];
            arf_pkg::CFG_MAX:    cfg_max    = val[arf_pkg::IVL_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic write_all(logic en, int unsigned base, int unsigned hi, int unsigned lo,
                             int unsigned mn, int unsigned mx);
        write_reg(arf_pkg::CFG_ENABLE, arf_pkg::CFG_DATA_W'(en));
        write_reg(arf_pkg::CFG_BASE, arf_pkg::CFG_DATA_W'(base));
        write_reg(arf_pkg::CFG_HIGH, arf_pkg::CFG_DATA_W'(hi));
        write_reg(arf_pkg::CFG_LOW, arf_pkg::CFG_DATA_W'(lo));
        write_reg(arf_pkg::CFG_MIN, arf_pkg::CFG_DATA_W'(mn));
        write_reg(arf_pkg::CFG_MAX, arf_pkg::CFG_DATA_W'(mx));
    endtask

    // reset defaults, disabled items, grow and shrink, zero span, saturation
    task automatic test_reset_defaults();
        send_sample(1'b0, 64'd5, 64'd3);
        send_sample(1'b1, 64'd100, 64'd10);
        wait_idle();
        write_reg(arf_pkg::CFG_ENABLE, arf_pkg::CFG_DATA_W'(1));
        send_sample(1'b0, 64'd200, 64'd60);
        send_sample(1'b0, 64'd300, 64'd110);
        send_sample(1'b0, 64'd300, 64'd999);
        send_sample(1'b0, 64'd400, 64'd310);
        send_sample(1'b0, 64'd500, 64'd410);
        send_sample(1'b0, 64'd600, 64'd410);
        send_sample(1'b0, 64'd700, 64'd411);
        send_sample(1'b0, 64'd800, 64'd400);
    endtask

    // counter wrap and products beyond 64 bits
    task automatic test_wide_counters();
        send_sample(1'b1, 64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFF0);
        send_sample(1'b0, 64'h0000_0000_0000_0100, 64'h0000_0000_0000_0010);
        send_sample(1'b1, 64'd0, 64'd0);
        send_sample(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE);
        send_sample(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    // extreme and inverted bounds, extreme thresholds
    task automatic test_bounds();
        wait_idle();
        write_all(1'b1, 1000000, 0, 100, 1, 1000000);
        send_sample(1'b1, 64'd0, 64'd0);
        send_sample(1'b0, 64'd100, 64'd50);
        send_sample(1'b0, 64'd200, 64'd100);
        send_sample(1'b0, 64'd300, 64'd101);
        wait_idle();
        write_all(1'b1, 1000, 100, 0, 500000, 2000);
        send_sample(1'b1, 64'd0, 64'd0);
        send_sample(1'b0, 64'd100, 64'd100);
        wait_idle();
        write_all(1'b1, 1, 22, 18, 1, 1000000);
        send_sample(1'b1, 64'd0, 64'd0);
        send_sample(1'b0, 64'd100, 64'd90);
        wait_idle();
        write_reg(arf_pkg::CFG_ENABLE, arf_pkg::CFG_DATA_W'(0));
        send_sample(1'b1, 64'd7, 64'd7);
    endtask

    task automatic random_config();
        int unsigned base;
        int unsigned mn;
        int unsigned mx;
        int unsigned lo;
        int unsigned hi;
        case ($urandom_range(0, 3))
            0:       base = 1;
            1:       base = 1000000;
            2:       base = $urandom_range(1, 60);
            default: base = $urandom_range(100, 300000);
        endcase
        case ($urandom_range(0, 2))
            0:       mn = 1;
            1:       mn = $urandom_range(1, base);
            default: mn = $urandom_range(1, 1000000);
        endcase
        case ($urandom_range(0, 2))
            0:       mx = 1000000;
            1:       mx = (base * 3 > 1000000) ? 1000000 : $urandom_range(base, base * 3);
            default: mx = $urandom_range(1, 1000000);
        endcase
        lo = $urandom_range(0, 60);
        hi = $urandom_range(lo, 100);
        if ($urandom_range(0, 7) == 0)
        begin
            lo = $urandom_range(0, 100);
            hi = $urandom_range(0, 100);
        end
        write_all($urandom_range(0, 5) != 0, base, hi, lo, mn, mx);
    endtask

    task automatic run_random_phase(int unsigned count);
        int unsigned                mode;
        int unsigned                mode_left;
        int unsigned                pct;
        int unsigned                sel;
        logic [arf_pkg::TICK_W-1:0] dt;
        logic [arf_pkg::TICK_W-1:0] db;
        mode_left = 0;
        mode = 0;
        if ($urandom_range(0, 1) == 0)
            send_sample(1'b1, total_now, busy_now);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(2, 8);
            end
            mode_left--;
            case (mode)
                0:       pct = $urandom_range(cfg_high, 100);
                1:       pct = $urandom_range(0, cfg_low);
                default: pct = $urandom_range(0, 100);
            endcase
            sel = $urandom_range(0, 19);
            if (sel < 2)
            begin
                // restart or a noise item with arbitrary counter values
                total_now = {$urandom, $urandom};
                busy_now  = {$urandom, $urandom};
                send_sample(sel == 0, total_now, busy_now);
            end
            else
            begin
                if (sel == 2)
                begin
                    dt = '0;
                    db = arf_pkg::TICK_W'($urandom_range(0, 50));
                end
                else if (sel == 3)
                begin
                    dt = {$urandom, $urandom};
                    db = (mode == 0) ? dt - (dt >> $urandom_range(2, 8))
                                     : dt >> $urandom_range(1, 12);
                end
                else
                begin
                    dt = arf_pkg::TICK_W'($urandom_range(1, 1000000));
                    db = dt * pct / 100 + arf_pkg::TICK_W'($urandom_range(0, 1));
                end
                total_now = total_now + dt;
                busy_now  = busy_now + db;
                send_sample(1'b0, total_now, busy_now);
            end
        end
    endtask

    task automatic test_random();
        total_now = {$urandom, $urandom};
        busy_now  = {$urandom, $urandom};
        for (int p = 0; p < 8; p++)
        begin
            wait_idle();
            if (p == 7)
                no_idle = 1'b1;
            random_config();
            run_random_phase(50);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        stall_left = 0;
        no_idle   = 1'b0;
        error_count = 0;
        samples_sent = 0;
        results_checked = 0;
        grow_count = 0;
        shrink_count = 0;
        restart_count = 0;
        cycle_count = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_wide_counters();
        test_bounds();
        test_random();
        wait_idle();

        $display("Sent %0d samples (%0d restarts), checked %0d results", samples_sent,
                 restart_count, results_checked);
        $display("Interval grew %0d times and shrank %0d times over 12 register settings",
                 grow_count, shrink_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
